// ----- hdl/fsip_pkg.sv -----
package fsip_pkg;

  // Character codes used by the formatter.
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_LX      = 8'h78;
  localparam logic [7:0] CH_UX      = 8'h58;
  localparam logic [7:0] CH_S       = 8'h73;

  // Widths of the argument and of the decimal digit register.
  localparam int ARG_W      = 32;
  localparam int NUM_DIGITS = 10;
  localparam int DIG_W      = 4 * NUM_DIGITS;
  localparam int CNT_W      = 31;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // Work handed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_CHAR,
    OP_DEC,
    OP_HEX,
    OP_END
  } op_kind_t;

  typedef struct packed {
    logic             pre_en;
    logic [7:0]       pre_char;
    op_kind_t         kind;
    logic [7:0]       chr;
    logic [ARG_W-1:0] value;
  } fsip_op_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PRE,
    B_MAIN,
    B_CONV,
    B_SKIP,
    B_DIGIT,
    B_END
  } back_state_t;

  // Lowercase hex character for one digit.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CH_ZERO + {4'd0, nib};
    end else begin
      c = CH_LOWER_A + {4'd0, nib} - 8'd10;
    end
    return c;
  endfunction

endpackage

// ----- hdl/fsip_if.sv -----
// Format input channel: one format byte with its argument word per transfer.
interface fsip_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  fmt_byte;
  logic [31:0] arg_value;

  modport source (output valid, command, fmt_byte, arg_value, input ready);
  modport sink   (input valid, command, fmt_byte, arg_value, output ready);
endinterface

// Result channel: one emitted character or count word per transfer.
interface fsip_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_char;
  logic        char_valid;
  logic [30:0] total_count;
  logic        last;

  modport source (output valid, out_char, char_valid, total_count, last, input ready);
  modport sink   (input valid, out_char, char_valid, total_count, last, output ready);
endinterface

// ----- hdl/fsip_front.sv -----
module fsip_front (
  input  logic               clk,
  input  logic               rst_n,
  fsip_in_if.sink            in_ch,
  input  logic               push_ready,
  output logic               push,
  output fsip_pkg::fsip_op_t push_data
);
  import fsip_pkg::*;

  logic percent_pending_r;
  logic percent_pending_nxt;
  logic accept;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;

  // Classify the incoming word and build the work record for the back end.
  always_comb begin
    percent_pending_nxt = percent_pending_r;
    push                = 1'b0;
    push_data.pre_en    = 1'b0;
    push_data.pre_char  = CH_PERCENT;
    push_data.kind      = OP_CHAR;
    push_data.chr       = in_ch.fmt_byte;
    push_data.value     = in_ch.arg_value;
    if (accept) begin
      if (in_ch.command) begin
        push                = 1'b1;
        push_data.kind      = OP_END;
        push_data.pre_en    = percent_pending_r;
        percent_pending_nxt = 1'b0;
      end else if (percent_pending_r) begin
        percent_pending_nxt = 1'b0;
        push                = 1'b1;
        if (in_ch.fmt_byte == CH_PERCENT) begin
          push_data.kind = OP_CHAR;
        end else if (in_ch.fmt_byte == CH_D) begin
          push_data.kind     = OP_DEC;
          push_data.pre_en   = in_ch.arg_value[ARG_W-1];
          push_data.pre_char = CH_MINUS;
          if (in_ch.arg_value[ARG_W-1]) begin
            push_data.value = ~in_ch.arg_value + 32'd1;
          end
        end else if (in_ch.fmt_byte == CH_LX || in_ch.fmt_byte == CH_UX) begin
          push_data.kind = OP_HEX;
        end else if (in_ch.fmt_byte == CH_S) begin
          // The string selector produces nothing.
          push = 1'b0;
        end else begin
          push_data.pre_en = 1'b1;
          push_data.kind   = OP_CHAR;
        end
      end else if (in_ch.fmt_byte == CH_PERCENT) begin
        percent_pending_nxt = 1'b1;
      end else begin
        push = 1'b1;
      end
    end
  end

  // Pending-percent flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      percent_pending_r <= 1'b0;
    end else begin
      percent_pending_r <= percent_pending_nxt;
    end
  end

endmodule

// ----- hdl/fsip_queue.sv -----
module fsip_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  fsip_pkg::fsip_op_t push_data,
  output logic               push_ready,
  input  logic               pop,
  output logic               pop_valid,
  output fsip_pkg::fsip_op_t pop_data
);
  import fsip_pkg::*;

  fsip_op_t   slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Storage of the two queue entries.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

endmodule

// ----- hdl/fsip_back.sv -----
module fsip_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  input  fsip_pkg::fsip_op_t pop_data,
  output logic               pop,
  fsip_out_if.source         out_ch
);
  import fsip_pkg::*;

  back_state_t      state_r, state_nxt;
  fsip_op_t         op_r, op_nxt;
  logic [ARG_W-1:0] bin_r, bin_nxt;
  logic [DIG_W-1:0] dig_r, dig_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [3:0]       rem_r, rem_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] count_inc;

  logic             out_valid_r;
  logic [7:0]       out_char_r;
  logic             char_valid_r;
  logic [CNT_W-1:0] total_count_r;
  logic             last_r;

  logic             slot_free;
  logic             emit;
  logic [7:0]       e_char;
  logic             e_valid;
  logic             e_last;

  // One double-dabble step: adjust each BCD digit, then shift in a binary bit.
  function automatic logic [DIG_W-1:0] dabble(input logic [DIG_W-1:0] d, input logic b);
    logic [DIG_W-1:0] a;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      a[4*i +: 4] = (d[4*i +: 4] >= 4'd5) ? d[4*i +: 4] + 4'd3 : d[4*i +: 4];
    end
    return {a[DIG_W-2:0], b};
  endfunction

  // First state for a record's main work.
  function automatic back_state_t dispatch(input op_kind_t k);
    back_state_t s;
    case (k)
      OP_CHAR: s = B_MAIN;
      OP_DEC:  s = B_CONV;
      OP_HEX:  s = B_SKIP;
      OP_END:  s = B_END;
      default: s = B_IDLE;
    endcase
    return s;
  endfunction

  assign slot_free = !out_valid_r || out_ch.ready;
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + 31'd1;

  // Sequencer: pops a record and emits its characters, at most one per cycle, while the output slot is free.
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    bin_nxt   = bin_r;
    dig_nxt   = dig_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    pop       = 1'b0;
    emit      = 1'b0;
    e_char    = 8'd0;
    e_valid   = 1'b1;
    e_last    = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (pop_valid) begin
          pop     = 1'b1;
          op_nxt  = pop_data;
          bin_nxt = pop_data.value;
          dig_nxt = (pop_data.kind == OP_HEX) ?
                    {{(DIG_W-ARG_W){1'b0}}, pop_data.value} : '0;
          cnt_nxt = 5'd0;
          rem_nxt = 4'(NUM_DIGITS);
          state_nxt = pop_data.pre_en ? B_PRE : dispatch(pop_data.kind);
        end
      end
      B_PRE: begin
        if (slot_free) begin
          emit      = 1'b1;
          e_char    = op_r.pre_char;
          state_nxt = dispatch(op_r.kind);
        end
      end
      B_MAIN: begin
        if (slot_free) begin
          emit      = 1'b1;
          e_char    = op_r.chr;
          e_last    = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      B_CONV: begin
        dig_nxt = dabble(dig_r, bin_r[ARG_W-1]);
        bin_nxt = {bin_r[ARG_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(ARG_W - 1)) begin
          state_nxt = B_SKIP;
        end
      end
      B_SKIP: begin
        // Drop leading zero digits, keeping at least one.
        if (dig_r[DIG_W-1 -: 4] == 4'd0 && rem_r != 4'd1) begin
          dig_nxt = {dig_r[DIG_W-5:0], 4'd0};
          rem_nxt = rem_r - 4'd1;
        end else begin
          state_nxt = B_DIGIT;
        end
      end
      B_DIGIT: begin
        if (slot_free) begin
          emit    = 1'b1;
          e_char  = hex_char(dig_r[DIG_W-1 -: 4]);
          e_last  = (rem_r == 4'd1);
          dig_nxt = {dig_r[DIG_W-5:0], 4'd0};
          rem_nxt = rem_r - 4'd1;
          if (rem_r == 4'd1) begin
            state_nxt = B_IDLE;
          end
        end
      end
      B_END: begin
        if (slot_free) begin
          emit      = 1'b1;
          e_valid   = 1'b0;
          e_last    = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // Character count: advances on each character, saturating, and clears after the count word.
  always_comb begin
    count_nxt = count_r;
    if (emit) begin
      count_nxt = e_valid ? count_inc : '0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers and the output word.
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    bin_r <= bin_nxt;
    dig_r <= dig_nxt;
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    if (emit) begin
      out_char_r    <= e_char;
      char_valid_r  <= e_valid;
      total_count_r <= e_valid ? count_inc : count_r;
      last_r        <= e_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_char    = out_char_r;
  assign out_ch.char_valid  = char_valid_r;
  assign out_ch.total_count = total_count_r;
  assign out_ch.last        = last_r;

endmodule

// ----- hdl/format_stream_integer_printer.sv -----
// Unstalled, a plain character's word goes into the queue, then the back end's record
// register, then the output register on out_ch. %d runs an optional minus-sign step,
// 32 binary-to-BCD steps, then ten zero-skip or digit steps, one per cycle (a digit step
// only while the output is free), plus the step leaving the zero skip; %x skips the BCD steps.
// Throughput: one result word per cycle at most; the back end works one record at a time.
// Reset (rst_n low, synchronous) clears the pending percent, count, queue and output.
module format_stream_integer_printer (
  input  logic       clk,
  input  logic       rst_n,
  fsip_in_if.sink    in_ch,
  fsip_out_if.source out_ch
);
  import fsip_pkg::*;

  logic     push;
  logic     push_ready;
  fsip_op_t push_data;
  logic     pop;
  logic     pop_valid;
  fsip_op_t pop_data;

  // Front end: decodes format bytes.
  fsip_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_ready (push_ready),
    .push       (push),
    .push_data  (push_data)
  );

  // Queue between the two halves.
  fsip_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  // Back end: converts numbers and emits characters.
  fsip_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

// ----- test/format_stream_integer_printer_checker.sv -----
// Watches both channels, predicts the printed characters for every accepted
// format word and compares each result word with the oldest prediction.
module format_stream_integer_printer_checker
  import fsip_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  fsip_in_if          in_mon,
  fsip_out_if         out_mon,
  output int unsigned fail_count,
  output int unsigned words_waiting,
  output int unsigned words_checked
);

  // One predicted result word.
  typedef struct packed {
    logic [7:0]       chr;
    logic             is_char;
    logic [CNT_W-1:0] count;
    logic             last;
  } printed_word_t;

  printed_word_t    printed_q[$];
  logic             pct_pending;
  logic [CNT_W-1:0] chars_so_far;

  // Append one character or count word, advancing the saturating count on a character.
  task automatic put_word(input logic [7:0] chr, input logic is_char);
    printed_word_t w;
    if (is_char && chars_so_far != COUNT_MAX) begin
      chars_so_far = chars_so_far + 1'b1;
    end
    w.chr     = is_char ? chr : 8'h00;
    w.is_char = is_char;
    w.count   = chars_so_far;
    w.last    = 1'b0;
    printed_q.push_back(w);
  endtask

  // Print a magnitude in the given radix, most significant digit first.
  task automatic put_digits(input logic [31:0] mag, input int unsigned radix);
    logic [3:0] dig [NUM_DIGITS];
    int         n;
    n = 0;
    do begin
      dig[n] = 4'(mag % radix);
      mag    = mag / radix;
      n++;
    end while (mag != 0 && n < NUM_DIGITS);
    for (int i = n - 1; i >= 0; i--) begin
      put_word((dig[i] < 4'd10) ? CH_ZERO + 8'(dig[i]) : CH_LOWER_A + 8'(dig[i]) - 8'd10,
               1'b1);
    end
  endtask

  // Work out every result word that one format word causes.
  task automatic predict_format_word(input logic end_cmd, input logic [7:0] b,
                                     input logic [31:0] arg);
    int unsigned   before_size;
    logic [31:0]   mag;
    printed_word_t tail;
    before_size = printed_q.size();
    if (end_cmd) begin
      // A dangling percent is flushed before the count word.
      if (pct_pending) begin
        put_word(CH_PERCENT, 1'b1);
      end
      put_word(8'h00, 1'b0);
      pct_pending  = 1'b0;
      chars_so_far = '0;
    end else if (pct_pending) begin
      pct_pending = 1'b0;
      case (b)
        CH_PERCENT: begin
          put_word(CH_PERCENT, 1'b1);
        end
        CH_D: begin
          mag = arg;
          if (arg[31]) begin
            put_word(CH_MINUS, 1'b1);
            mag = -arg;
          end
          put_digits(mag, 10);
        end
        CH_LX, CH_UX: begin
          put_digits(arg, 16);
        end
        CH_S: begin
          // The string conversion prints nothing.
        end
        default: begin
          put_word(CH_PERCENT, 1'b1);
          put_word(b, 1'b1);
        end
      endcase
    end else if (b == CH_PERCENT) begin
      pct_pending = 1'b1;
    end else begin
      put_word(b, 1'b1);
    end
    // Flag the final word of this item.
    if (printed_q.size() > before_size) begin
      tail      = printed_q.pop_back();
      tail.last = 1'b1;
      printed_q.push_back(tail);
    end
  endtask

  // Predict on input words, then compare output words in the same edge.
  always @(posedge clk) begin
    printed_word_t want;
    if (!rst_n) begin
      pct_pending  = 1'b0;
      chars_so_far = '0;
      printed_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        predict_format_word(in_mon.command, in_mon.fmt_byte, in_mon.arg_value);
      end
      if (out_mon.valid && out_mon.ready) begin
        words_checked++;
        if (printed_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("[%0t] unexpected result word: char=%h valid=%b count=%0d last=%b",
                     $realtime, out_mon.out_char, out_mon.char_valid,
                     out_mon.total_count, out_mon.last);
          end
        end else begin
          want = printed_q.pop_front();
          if (out_mon.out_char !== want.chr || out_mon.char_valid !== want.is_char ||
              out_mon.total_count !== want.count || out_mon.last !== want.last) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("[%0t] result word differs: expected char=%h valid=%b count=%0d last=%b",
                       $realtime, want.chr, want.is_char, want.count, want.last);
              $display("[%0t]                        actual char=%h valid=%b count=%0d last=%b",
                       $realtime, out_mon.out_char, out_mon.char_valid,
                       out_mon.total_count, out_mon.last);
            end
          end
        end
      end
    end
    words_waiting = printed_q.size();
  end

endmodule

// ----- test/format_stream_integer_printer_tb.sv -----
module format_stream_integer_printer_tb;
  import fsip_pkg::*;

  localparam logic        CMD_BYTE   = 1'b0;
  localparam logic        CMD_END    = 1'b1;
  localparam int unsigned NUM_WORDS  = 410;
  localparam int unsigned HOLD_OFF   = 600;
  localparam int unsigned CYCLE_CAP  = 400000;
  localparam int unsigned TAIL_WAIT  = 100;

  typedef struct packed {
    logic        command;
    logic [7:0]  fmt_byte;
    logic [31:0] arg_value;
  } format_word_t;

  logic clk = 1'b0;
  logic rst_n;

  fsip_in_if  in_ch ();
  fsip_out_if out_ch ();

  format_word_t format_q[$];
  int unsigned  words_sent;
  int unsigned  fail_count;
  int unsigned  words_waiting;
  int unsigned  words_checked;

  always #5 clk = ~clk;

  format_stream_integer_printer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  format_stream_integer_printer_checker printer_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .words_waiting (words_waiting),
    .words_checked (words_checked)
  );

  task automatic add_word(input logic cmd, input logic [7:0] b, input logic [31:0] arg);
    format_word_t w;
    w.command   = cmd;
    w.fmt_byte  = b;
    w.arg_value = arg;
    format_q.push_back(w);
  endtask

  // Argument values weighted toward zero, small numbers and the extremes.
  function automatic logic [31:0] pick_arg();
    logic [31:0] v;
    case ($urandom_range(5))
      0: v = 32'h0;
      1: v = $urandom_range(99);
      2: v = 32'h8000_0000 | $urandom_range(99);
      3: v = $urandom;
      4: begin
        case ($urandom_range(2))
          0: v = 32'hFFFF_FFFF;
          1: v = 32'h7FFF_FFFF;
          default: v = 32'h8000_0000;
        endcase
      end
      default: v = $urandom >> $urandom_range(31);
    endcase
    return v;
  endfunction

  // A byte that does not open a conversion.
  function automatic logic [7:0] pick_plain();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == CH_PERCENT) begin
      b = 8'h41;
    end
    return b;
  endfunction

  // A selector after a percent: every conversion, plus arbitrary bytes.
  function automatic logic [7:0] pick_selector();
    logic [7:0] b;
    case ($urandom_range(7))
      0: b = CH_PERCENT;
      1, 2: b = CH_D;
      3: b = CH_LX;
      4: b = CH_UX;
      5: b = CH_S;
      default: b = 8'($urandom_range(255));
    endcase
    return b;
  endfunction

  // Directed words first, then random formats with some noise mixed in.
  task automatic build_format_stream();
    int unsigned segs;
    // Empty format reports a zero count.
    add_word(CMD_END, 8'h00, 32'h0);
    add_word(CMD_BYTE, 8'h41, 32'hFFFF_FFFF);
    add_word(CMD_BYTE, 8'h00, 32'h0);
    add_word(CMD_BYTE, 8'hFF, 32'h5A5A_A5A5);
    add_word(CMD_BYTE, CH_PERCENT, 32'h0);
    add_word(CMD_BYTE, CH_PERCENT, 32'h0);
    add_word(CMD_BYTE, CH_PERCENT, 32'h0);
    add_word(CMD_BYTE, CH_D, 32'h0);
    // Most negative integer prints eleven characters.
    add_word(CMD_BYTE, CH_PERCENT, 32'h0);
    add_word(CMD_BYTE, CH_D, 32'h8000_0000);
    add_word(CMD_BYTE, CH_PERCENT, 32'h0);
    add_word(CMD_BYTE, CH_D, 32'h7FFF_FFFF);
    add_word(CMD_BYTE, CH_PERCENT, 32'h0);
    add_word(CMD_BYTE, CH_D, 32'hFFFF_FFFF);
    add_word(CMD_BYTE, CH_PERCENT, 32'h0);
    add_word(CMD_BYTE, CH_LX, 32'hFFFF_FFFF);
    add_word(CMD_BYTE, CH_PERCENT, 32'h0);
    add_word(CMD_BYTE, CH_UX, 32'h0);
    // String selector prints nothing and ignores its argument.
    add_word(CMD_BYTE, CH_PERCENT, 32'h0);
    add_word(CMD_BYTE, CH_S, 32'h1234_5678);
    // Unknown selector prints the percent and the byte.
    add_word(CMD_BYTE, CH_PERCENT, 32'h0);
    add_word(CMD_BYTE, 8'h71, 32'h0);
    // End with a percent still open flushes it before the count.
    add_word(CMD_BYTE, CH_PERCENT, 32'h0);
    add_word(CMD_END, 8'hFF, 32'hFFFF_FFFF);

    while (format_q.size() < NUM_WORDS) begin
      if ($urandom_range(9) < 8) begin
        // Well-formed format: plain bytes and conversions, then end.
        segs = $urandom_range(1, 10);
        repeat (segs) begin
          if ($urandom_range(2) == 0) begin
            add_word(CMD_BYTE, pick_plain(), $urandom);
          end else begin
            add_word(CMD_BYTE, CH_PERCENT, $urandom);
            add_word(CMD_BYTE, pick_selector(), pick_arg());
          end
        end
        if ($urandom_range(7) == 0) begin
          add_word(CMD_BYTE, CH_PERCENT, $urandom);
        end
        add_word(CMD_END, 8'($urandom_range(255)), $urandom);
      end else begin
        // Noise: arbitrary words, occasionally an end command.
        repeat ($urandom_range(1, 6)) begin
          add_word(($urandom_range(9) == 0) ? CMD_END : CMD_BYTE,
                   ($urandom_range(3) == 0) ? CH_PERCENT : 8'($urandom_range(255)),
                   $urandom);
        end
      end
    end
  endtask

  // Stimulus, end of run and verdict.
  initial begin
    int unsigned idx;
    int unsigned burst;
    int unsigned end_words;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.command    <= CMD_BYTE;
    in_ch.fmt_byte   <= 8'h00;
    in_ch.arg_value  <= 32'h0;
    words_sent        = 0;
    build_format_stream();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Send in bursts; some bursts run straight into the next.
    idx = 0;
    while (idx < format_q.size()) begin
      burst = $urandom_range(1, 16);
      for (int k = 0; k < burst && idx < format_q.size(); k++) begin
        in_ch.valid     <= 1'b1;
        in_ch.command   <= format_q[idx].command;
        in_ch.fmt_byte  <= format_q[idx].fmt_byte;
        in_ch.arg_value <= format_q[idx].arg_value;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        idx++;
        words_sent = idx;
      end
      if ($urandom_range(3) != 0 && idx < format_q.size()) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;

    // Let the checker see the last accepted word before draining.
    @(posedge clk);
    while (words_waiting != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    end_words = 0;
    foreach (format_q[i]) begin
      if (format_q[i].command == CMD_END) end_words++;
    end
    $display("Run covered %0d format words (%0d end commands) and checked %0d result words.",
             words_sent, end_words, words_checked);
    $display("The receiver held off once for %0d cycles while input kept coming.", HOLD_OFF);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Receiver: stall phases of random length and density, one long hold-off.
  initial begin
    int unsigned phase_len;
    int unsigned stall_pct;
    bit          held;
    out_ch.ready <= 1'b0;
    held          = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && words_sent >= 150) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end
      phase_len = $urandom_range(5, 60);
      case ($urandom_range(3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 50;
        default: stall_pct = 75;
      endcase
      repeat (phase_len) begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
        @(posedge clk);
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    repeat (CYCLE_CAP) @(posedge clk);
    $display("Run stopped at the cycle limit with %0d result words outstanding.",
             words_waiting);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/fsip_pkg.sv
hdl/fsip_if.sv
hdl/fsip_front.sv
hdl/fsip_queue.sv
hdl/fsip_back.sv
hdl/format_stream_integer_printer.sv
test/format_stream_integer_printer_checker.sv
test/format_stream_integer_printer_tb.sv
